### design/ewss_pkg.sv
// shared constants, types and microcode rom for the sma-seeded ema core
`default_nettype none

package ewss_pkg;

    // field widths and sizing
    localparam int MAX_WINDOW = 1024;
    localparam int WIN_W      = 11;
    localparam int PRICE_W    = 32;
    localparam int STAMP_W    = 32;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(14);
    localparam int PER_MAX    = (MAX_WINDOW < 2**WIN_W) ? MAX_WINDOW : 2**WIN_W - 1;

    // running sum, saturating at max window times max price
    localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(64'(MAX_WINDOW) * 64'hFFFF_FFFF);

    // divider sizing
    localparam int Q_W   = SUM_W;
    localparam int DV_W  = WIN_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [Q_W-1:0] PRICE_MAX_Q = Q_W'({PRICE_W{1'b1}});

    // smoothing factor k, unsigned with K_FRAC fraction bits
    localparam int K_FRAC = 24;
    localparam int K_W    = K_FRAC + 1;
    localparam int KD_W   = K_FRAC + 2;
    localparam int PROD_W = PRICE_W + K_W;
    localparam logic [K_W-1:0]    K_ONE  = K_W'(2**K_FRAC);
    localparam logic [KD_W-1:0]   K_TWO  = KD_W'(2**(K_FRAC + 1));
    localparam logic [PROD_W-1:0] K_HALF = PROD_W'(2**(K_FRAC - 1));

    // microcode word fields
    localparam int PC_W  = 4;
    localparam int OP_W  = 4;
    localparam int CND_W = 3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP       = OP_W'(0);
    localparam logic [OP_W-1:0] OP_BOOK      = OP_W'(1);
    localparam logic [OP_W-1:0] OP_DIV_SEED  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_DIV_K     = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DIV_STEP  = OP_W'(4);
    localparam logic [OP_W-1:0] OP_SEED_DONE = OP_W'(5);
    localparam logic [OP_W-1:0] OP_MUL_CLOSE = OP_W'(6);
    localparam logic [OP_W-1:0] OP_MUL_AVG   = OP_W'(7);
    localparam logic [OP_W-1:0] OP_UPD_DONE  = OP_W'(8);
    localparam logic [OP_W-1:0] OP_WRITE_OUT = OP_W'(9);

    // jump conditions
    localparam logic [CND_W-1:0] C_NEVER    = CND_W'(0);
    localparam logic [CND_W-1:0] C_ALWAYS   = CND_W'(1);
    localparam logic [CND_W-1:0] C_NO_XFER  = CND_W'(2);
    localparam logic [CND_W-1:0] C_WARM     = CND_W'(3);
    localparam logic [CND_W-1:0] C_UPD      = CND_W'(4);
    localparam logic [CND_W-1:0] C_DIV_MORE = CND_W'(5);
    localparam logic [CND_W-1:0] C_OUT_BUSY = CND_W'(6);

    // program addresses
    localparam logic [PC_W-1:0] UA_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] UA_BOOK     = PC_W'(1);
    localparam logic [PC_W-1:0] UA_BR_WARM  = PC_W'(2);
    localparam logic [PC_W-1:0] UA_BR_UPD   = PC_W'(3);
    localparam logic [PC_W-1:0] UA_SEED_LD  = PC_W'(4);
    localparam logic [PC_W-1:0] UA_SEED_DIV = PC_W'(5);
    localparam logic [PC_W-1:0] UA_SEED_END = PC_W'(6);
    localparam logic [PC_W-1:0] UA_K_LD     = PC_W'(7);
    localparam logic [PC_W-1:0] UA_K_DIV    = PC_W'(8);
    localparam logic [PC_W-1:0] UA_MUL_C    = PC_W'(9);
    localparam logic [PC_W-1:0] UA_MUL_A    = PC_W'(10);
    localparam logic [PC_W-1:0] UA_UPD_END  = PC_W'(11);
    localparam logic [PC_W-1:0] UA_FIN      = PC_W'(12);
    localparam logic [PC_W-1:0] UA_RET      = PC_W'(13);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic warm;
        logic upd;
        logic div_more;
        logic out_busy;
    } dp_stat_t;

    // divider control
    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] steps;
    } div_ctl_t;

    // control store: one word per step, jump to target when cond holds
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            UA_IDLE:     w = '{OP_NOP,       C_NO_XFER,  UA_IDLE};
            UA_BOOK:     w = '{OP_BOOK,      C_NEVER,    UA_IDLE};
            UA_BR_WARM:  w = '{OP_NOP,       C_WARM,     UA_FIN};
            UA_BR_UPD:   w = '{OP_NOP,       C_UPD,      UA_K_LD};
            UA_SEED_LD:  w = '{OP_DIV_SEED,  C_NEVER,    UA_IDLE};
            UA_SEED_DIV: w = '{OP_DIV_STEP,  C_DIV_MORE, UA_SEED_DIV};
            UA_SEED_END: w = '{OP_SEED_DONE, C_ALWAYS,   UA_FIN};
            UA_K_LD:     w = '{OP_DIV_K,     C_NEVER,    UA_IDLE};
            UA_K_DIV:    w = '{OP_DIV_STEP,  C_DIV_MORE, UA_K_DIV};
            UA_MUL_C:    w = '{OP_MUL_CLOSE, C_NEVER,    UA_IDLE};
            UA_MUL_A:    w = '{OP_MUL_AVG,   C_NEVER,    UA_IDLE};
            UA_UPD_END:  w = '{OP_UPD_DONE,  C_NEVER,    UA_IDLE};
            UA_FIN:      w = '{OP_WRITE_OUT, C_OUT_BUSY, UA_FIN};
            UA_RET:      w = '{OP_NOP,       C_ALWAYS,   UA_IDLE};
            default:     w = '{OP_NOP,       C_ALWAYS,   UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/ema_with_sma_seed_core.sv
// top level of the sma-seeded exponential moving average core
`default_nettype none

// One closing price (unsigned Q16.16) per bar goes in and one result per bar
// comes out, in order. The first window_length-1 bars of a series return zero
// with the valid flag low; the bar that completes the window returns the
// rounded simple average, and later bars the exponential update with
// k = 2/(P+1). A bar is taken only while the microcode sequencer sits in its
// idle step. The seeding bar runs 42 steps of the shared bit-serial divider,
// and later bars run 26 divider steps for k, then two passes through the one
// 32x25 multiplier. The result sits in an output register, so the next bar is
// taken while an earlier result waits for m_tready.
// window_length is written through cfg_wr_en/cfg_wr_data only while idle;
// the user is bound to this, the core itself does not enforce it.
// 0 acts as 1 and values above 1024 act as 1024.
module ema_with_sma_seed_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write
    input  wire logic                          cfg_wr_en,
    input  wire logic [ewss_pkg::WIN_W-1:0]    cfg_wr_data,
    // input bars
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,  // close_price, bar_stamp
    input  wire logic                          s_tuser,  // series_start
    // results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [63:0]                   m_tdata,  // average_value, stamp_out
    output logic                               m_tuser   // value_valid
);
    import ewss_pkg::*;

    logic [WIN_W-1:0]   win_reg;
    logic [WIN_W-1:0]   period;
    logic               in_xfer;
    logic               idle;
    uword_t             uw;
    dp_stat_t           stat;
    logic [PRICE_W-1:0] m_average;
    logic [STAMP_W-1:0] m_stamp;

    // window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
        end else if (cfg_wr_en) begin
            win_reg <= cfg_wr_data;
        end
    end

    // effective period, clamped to the supported range
    always_comb begin
        if (win_reg == '0) begin
            period = WIN_W'(1);
        end else if (win_reg > WIN_W'(PER_MAX)) begin
            period = WIN_W'(PER_MAX);
        end else begin
            period = win_reg;
        end
    end

    assign s_tready = idle;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tdata  = {m_stamp, m_average};

    ewss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_xfer (in_xfer),
        .stat    (stat),
        .uw      (uw),
        .idle    (idle)
    );

    ewss_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .uw           (uw),
        .in_xfer      (in_xfer),
        .close_price  (s_tdata[PRICE_W-1:0]),
        .bar_stamp    (s_tdata[PRICE_W +: STAMP_W]),
        .series_start (s_tuser),
        .period       (period),
        .m_ready      (m_tready),
        .stat         (stat),
        .m_valid      (m_tvalid),
        .m_average    (m_average),
        .m_vflag      (m_tuser),
        .m_stamp      (m_stamp)
    );

endmodule

`default_nettype wire

### design/ewss_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module ewss_seq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_xfer,
    input  wire ewss_pkg::dp_stat_t stat,
    output ewss_pkg::uword_t      uw,
    output logic                  idle
);
    import ewss_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign uw   = ucode_rom(pc_reg);
    assign idle = (pc_reg == UA_IDLE);

    // condition decode
    always_comb begin
        unique case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_XFER:  jump = !in_xfer;
            C_WARM:     jump = stat.warm;
            C_UPD:      jump = stat.upd;
            C_DIV_MORE: jump = stat.div_more;
            C_OUT_BUSY: jump = stat.out_busy;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### design/ewss_div.sv
// restoring divider, one quotient bit per step
`default_nettype none

module ewss_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire ewss_pkg::div_ctl_t       ctl,
    input  wire logic [ewss_pkg::Q_W-1:0]  dividend,
    input  wire logic [ewss_pkg::DV_W-1:0] divisor,
    output logic      [ewss_pkg::Q_W-1:0]  quot,
    output logic                          more
);
    import ewss_pkg::*;

    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q_next;
    logic [DV_W-1:0]  rem_reg;
    logic [DV_W-1:0]  rem_next;
    logic [DV_W-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DV_W:0]    shifted;
    logic [DV_W:0]    trial;
    logic             ge;

    assign quot = q_reg;
    assign more = (cnt_reg > CNT_W'(1));

    // trial subtract of the shifted remainder
    always_comb begin
        shifted  = {rem_reg, q_reg[Q_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctl.load) begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = ctl.steps;
        end else if (ctl.step) begin
            q_next   = {q_reg[Q_W-2:0], ge};
            rem_next = ge ? trial[DV_W-1:0] : shifted[DV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (ctl.load) begin
            dvs_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

### design/ewss_dp.sv
// datapath: series state, divider, shared multiplier and output register
`default_nettype none

module ewss_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ewss_pkg::uword_t              uw,
    input  wire logic                          in_xfer,
    input  wire logic [ewss_pkg::PRICE_W-1:0]  close_price,
    input  wire logic [ewss_pkg::STAMP_W-1:0]  bar_stamp,
    input  wire logic                          series_start,
    input  wire logic [ewss_pkg::WIN_W-1:0]    period,
    input  wire logic                          m_ready,
    output ewss_pkg::dp_stat_t                 stat,
    output logic                               m_valid,
    output logic      [ewss_pkg::PRICE_W-1:0]  m_average,
    output logic                               m_vflag,
    output logic      [ewss_pkg::STAMP_W-1:0]  m_stamp
);
    import ewss_pkg::*;

    // latched bar
    logic [PRICE_W-1:0] close_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               start_reg;

    // series state
    logic [WIN_W-1:0]   bars_reg, bars_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PRICE_W-1:0] avg_reg, avg_next;
    logic               warm_reg, warm_next;
    logic               upd_reg, upd_next;

    // multiply pipeline
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PRICE_W-1:0] mul_a;
    logic [K_W-1:0]     mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  total;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [PRICE_W-1:0] m_avg_reg;
    logic               m_vflag_reg;
    logic [STAMP_W-1:0] m_stamp_reg;
    logic               out_busy;
    logic               out_wr;

    // bookkeeping terms
    logic [WIN_W-1:0]   bars_eff;
    logic [SUM_W-1:0]   sum_eff;
    logic [PRICE_W-1:0] avg_eff;
    logic [DV_W-1:0]    p_ext;
    logic [DV_W-1:0]    p_inc;
    logic [DV_W-1:0]    n_raw;
    logic [DV_W-1:0]    n_cnt;
    logic [SUM_W:0]     sum_add;

    // divider hookup
    div_ctl_t           dctl;
    logic [Q_W-1:0]     dividend;
    logic [DV_W-1:0]    divisor;
    logic [Q_W-1:0]     quot;
    logic               div_more;
    logic [K_W-1:0]     k_val;
    logic [KD_W-1:0]    k_num;

    ewss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .dividend (dividend),
        .divisor  (divisor),
        .quot     (quot),
        .more     (div_more)
    );

    assign out_busy = m_valid_reg && !m_ready;
    assign out_wr   = (uw.op == OP_WRITE_OUT) && !out_busy;
    assign k_val    = quot[K_W-1:0];

    assign stat.warm     = warm_reg;
    assign stat.upd      = upd_reg;
    assign stat.div_more = div_more;
    assign stat.out_busy = out_busy;

    assign m_valid   = m_valid_reg;
    assign m_average = m_avg_reg;
    assign m_vflag   = m_vflag_reg;
    assign m_stamp   = m_stamp_reg;

    // bar count and warm-up sum, with series restart folded in
    always_comb begin
        bars_eff = start_reg ? '0 : bars_reg;
        sum_eff  = start_reg ? '0 : sum_reg;
        avg_eff  = start_reg ? '0 : avg_reg;
        p_ext    = {1'b0, period};
        p_inc    = p_ext + DV_W'(1);
        n_raw    = {1'b0, bars_eff} + DV_W'(1);
        n_cnt    = (n_raw > p_inc) ? p_inc : n_raw;
        sum_add  = {1'b0, sum_eff} + (SUM_W + 1)'(close_reg);
    end

    // shared multiplier operands
    always_comb begin
        if (uw.op == OP_MUL_CLOSE) begin
            mul_a = close_reg;
            mul_b = k_val;
        end else begin
            mul_a = avg_reg;
            mul_b = K_ONE - k_val;
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
        total = acc_reg + prod_reg;
        k_num = K_TWO + KD_W'(p_inc >> 1);
    end

    // operation decode
    always_comb begin
        bars_next  = bars_reg;
        sum_next   = sum_reg;
        avg_next   = avg_reg;
        warm_next  = warm_reg;
        upd_next   = upd_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        dctl.load  = 1'b0;
        dctl.step  = 1'b0;
        dctl.steps = CNT_W'(Q_W);
        dividend   = sum_reg + SUM_W'(period >> 1);
        divisor    = p_ext;
        unique case (uw.op)
            OP_NOP: begin
            end
            OP_BOOK: begin
                warm_next = (n_cnt < p_ext);
                upd_next  = (n_cnt > p_ext);
                bars_next = (n_cnt > p_ext) ? period : n_cnt[WIN_W-1:0];
                if (n_cnt <= p_ext) begin
                    sum_next = (sum_add > {1'b0, SUM_CAP}) ? SUM_CAP : sum_add[SUM_W-1:0];
                end else begin
                    sum_next = sum_eff;
                end
                avg_next = (n_cnt < p_ext) ? '0 : avg_eff;
            end
            OP_DIV_SEED: begin
                dctl.load = 1'b1;
            end
            OP_DIV_K: begin
                dctl.load  = 1'b1;
                dctl.steps = CNT_W'(KD_W);
                dividend   = Q_W'(k_num) << (Q_W - KD_W);
                divisor    = p_inc;
            end
            OP_DIV_STEP: begin
                dctl.step = 1'b1;
            end
            OP_SEED_DONE: begin
                avg_next = (quot > PRICE_MAX_Q) ? '1 : quot[PRICE_W-1:0];
            end
            OP_MUL_CLOSE: begin
                prod_next = mul_p;
            end
            OP_MUL_AVG: begin
                acc_next  = prod_reg + K_HALF;
                prod_next = mul_p;
            end
            OP_UPD_DONE: begin
                avg_next = total[K_FRAC +: PRICE_W];
            end
            OP_WRITE_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // output valid: set on write, cleared on transfer
    always_comb begin
        if (out_wr) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bars_reg    <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            warm_reg    <= 1'b0;
            upd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            bars_reg    <= bars_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            warm_reg    <= warm_next;
            upd_reg     <= upd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (in_xfer) begin
            close_reg <= close_price;
            stamp_reg <= bar_stamp;
            start_reg <= series_start;
        end
        if (out_wr) begin
            m_avg_reg   <= warm_reg ? '0 : avg_reg;
            m_vflag_reg <= !warm_reg;
            m_stamp_reg <= stamp_reg;
        end
    end

endmodule

`default_nettype wire

### design/ewss_chk.sv
// port-level checker for the ema core, bound to the top level
`default_nettype none

module ewss_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // warm-up results carry a zero average
    a_warm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("invalid result with nonzero average");

    // one bar at a time: no transfer right after a transfer
    a_one_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a bar is in progress");

    // a new result never rises in the cycle right after an input transfer
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result too early after input transfer");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ema_with_sma_seed_core ewss_chk u_ewss_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/ema_bar_checker.sv
// checker for the sma-seeded ema core: watches both streams, predicts and compares
module ema_bar_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ewss_pkg::WIN_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [63:0]                s_tdata,   // close_price, bar_stamp
    input  logic                       s_tuser,   // series_start
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [63:0]                m_tdata,   // average_value, stamp_out
    input  logic                       m_tuser,   // value_valid
    output int                         pending_cnt,
    output int                         mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ewss_pkg::*;

    typedef struct {
        logic [31:0] average;
        logic        valid;
        logic [31:0] stamp;
    } bar_result_t;

    // own copy of the averaging state and the period register
    logic [WIN_W-1:0] window_len;
    int unsigned      bars_in_series;
    logic [63:0]      seed_total;
    logic [31:0]      ema_now;
    bar_result_t      expected_bars[$];

    // one bar through the seeded ema; updates the state, returns the result
    function automatic bar_result_t ema_predict(input logic [31:0] close,
                                                input logic [31:0] stamp,
                                                input logic restart);
        int unsigned period;
        int unsigned bar_no;
        logic [63:0] kfac;
        logic [63:0] acc;
        bar_result_t r;
        period = (window_len == 0) ? 1 :
                 ((window_len > MAX_WINDOW) ? MAX_WINDOW : int'(window_len));
        if (restart) begin
            bars_in_series = 0;
            seed_total     = '0;
            ema_now        = '0;
        end
        bar_no = bars_in_series + 1;
        if (bar_no > period)
            bar_no = period + 1;
        // warmup and seeding bars add to the running sum
        if (bar_no <= period) begin
            acc = seed_total + 64'(close);
            if (acc > 64'(SUM_CAP))
                acc = 64'(SUM_CAP);
            seed_total = acc;
        end
        if (bar_no < period) begin
            ema_now = '0;
            r.valid = 1'b0;
        end else if (bar_no == period) begin
            // rounded simple average seeds the series
            acc = (seed_total + 64'(period / 2)) / 64'(period);
            ema_now = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            r.valid = 1'b1;
        end else begin
            // k = 2/(P+1) rounded to 24 fraction bits
            kfac = ((64'd1 << (K_FRAC + 1)) + 64'((period + 1) / 2)) / 64'(period + 1);
            acc  = 64'(close) * kfac + 64'(ema_now) * ((64'd1 << K_FRAC) - kfac)
                   + (64'd1 << (K_FRAC - 1));
            ema_now = acc[K_FRAC +: 32];
            r.valid = 1'b1;
        end
        bars_in_series = (bar_no > period) ? period : bar_no;
        r.average = r.valid ? ema_now : 32'd0;
        r.stamp   = stamp;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // results are compared before new bars are queued, both sampled at the edge
    always @(posedge aclk) begin
        bar_result_t want;
        if (!aresetn) begin
            window_len     = WIN_RESET;
            bars_in_series = 0;
            seed_total     = '0;
            ema_now        = '0;
            expected_bars.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bars.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_bars.pop_front();
                    if (m_tdata[31:0] !== want.average)
                        report_mismatch("average_value", m_tdata[31:0], want.average);
                    if (m_tuser !== want.valid)
                        report_mismatch("value_valid", 32'(m_tuser), 32'(want.valid));
                    if (m_tdata[63:32] !== want.stamp)
                        report_mismatch("stamp_out", m_tdata[63:32], want.stamp);
                end
            end
            if (s_tvalid && s_tready)
                expected_bars.push_back(ema_predict(s_tdata[31:0], s_tdata[63:32], s_tuser));
            if (cfg_wr_en)
                window_len = cfg_wr_data;
        end
        pending_cnt <= expected_bars.size();
    end

endmodule

### tb/sv/tb.sv
// testbench top for the sma-seeded ema core: stimulus, stream pacing and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ewss_pkg::*;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata     = '0;   // close_price, bar_stamp
    logic             s_tuser     = 1'b0; // series_start
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [63:0]      m_tdata;            // average_value, stamp_out
    logic             m_tuser;            // value_valid

    int pending_cnt;
    int mismatch_count;

    // pacing knobs shared with the receiver process
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_request = 0;

    logic [31:0] bar_date = 32'h0001_0000;

    ema_with_sma_seed_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    ema_bar_checker bar_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .pending_cnt    (pending_cnt),
        .mismatch_count (mismatch_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_taken && hold_request != 0) begin
                hold_left  = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one bar and wait for its transfer; called just after a rising edge
    task automatic send_bar(input logic [31:0] close, input logic [31:0] stamp,
                            input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, close};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending_cnt != 0);
    endtask

    // period is only rewritten once every result is out and the core is idle
    task automatic program_window(input logic [WIN_W-1:0] w);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random segments: new period, then one to three series of random bars
    task automatic run_phase(input int tx_pct, input int rx_pct, input int n_bars,
                             input bit squeeze);
        int done;
        int w;
        int eff;
        int len;
        bit opening;
        bit squeeze_now;
        logic [31:0] price;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < n_bars) begin
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = 2047;
                2:       w = MAX_WINDOW;
                3:       w = $urandom_range(0, 2047);
                default: w = $urandom_range(1, 16);
            endcase
            program_window(w[WIN_W-1:0]);
            eff = (w == 0) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
            squeeze_now = squeeze;
            squeeze = 1'b0;
            // receiver stalls long enough for the core to back up its input
            if (squeeze_now)
                hold_request = 400;
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(1, (2 * eff + 6 < 60) ? 2 * eff + 6 : 60);
                if (squeeze_now)
                    len = 20;
                squeeze_now = 1'b0;
                // a series left open carries over into the new period
                opening = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 7))
                        0:       price = 32'd0;
                        1:       price = 32'hFFFF_FFFF;
                        default: price = $urandom;
                    endcase
                    bar_date = ($urandom_range(0, 3) == 0) ? $urandom : bar_date + 1;
                    send_bar(price, bar_date,
                             (i == 0 && opening) || ($urandom_range(0, 39) == 0));
                end
                done += len;
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset period of 14: warmup bars only
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 32'h0000_0000, 1'b0);

        // period 0 acts as 1: seed on the first bar, then k is exactly one
        program_window(0);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);

        // short period: full seed at the top price, updates, restart mid-series
        program_window(3);
        send_bar(32'hFFFF_FFFF, 32'h0000_0010, 1'b1);
        send_bar(32'hFFFF_FFFF, 32'h0000_0011, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'h0000_0012, 1'b0);
        send_bar(32'h0000_0000, 32'h0000_0013, 1'b0);
        send_bar(32'h0001_0000, 32'h0000_0014, 1'b0);
        send_bar(32'h1234_5678, 32'h0000_0015, 1'b1);
        send_bar(32'h8000_0001, 32'h0000_0016, 1'b0);
        send_bar(32'h0000_FFFF, 32'h0000_0017, 1'b0);

        // all-ones register clamps to the maximum window
        program_window(11'h7FF);
        send_bar(32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1);
        send_bar(32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
        send_bar(32'h0000_0000, 32'hA5A5_A5A6, 1'b0);

        // period changes inside one series
        program_window(4);
        send_bar(32'h0064_0000, 32'h0000_0020, 1'b1);
        send_bar(32'h00C8_8000, 32'h0000_0021, 1'b0);
        // past the new period without ever seeding: update runs from zero
        program_window(2);
        send_bar(32'h0190_0000, 32'h0000_0022, 1'b0);
        // count lands on the new period: seed from the sum so far
        program_window(3);
        send_bar(32'h0010_0000, 32'h0000_0023, 1'b0);
        // longer period: back to warmup
        program_window(8);
        send_bar(32'h0020_0000, 32'h0000_0024, 1'b0);
        send_bar(32'h0030_0000, 32'h0000_0025, 1'b0);

        run_phase(30, 55, 250, 1'b0);
        run_phase(55, 30, 250, 1'b0);
        run_phase(0, 0, 250, 1'b1);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/ewss_pkg.sv
design/ewss_seq.sv
design/ewss_div.sv
design/ewss_dp.sv
design/ema_with_sma_seed_core.sv
design/ewss_chk.sv
tb/sv/ema_bar_checker.sv
tb/sv/tb.sv
